>>> hdl/b64d_pkg.sv
// Package for the streaming base64 decoder.
// Holds the character map, result kinds and the job record between front and back.
// Depends on nothing; used by every module of the block.
package b64d_pkg;

    // Number of jobs the queue between front and back can hold.
    localparam int QUEUE_DEPTH = 4;

    // Internal codes for the two special characters, in 8-bit two's complement.
    localparam logic [7:0] CODE_INVALID = 8'hFE;
    localparam logic [7:0] CODE_PAD     = 8'hFF;

    // Kinds of result item.
    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_END_OK  = 2'd1,
        KIND_END_ERR = 2'd2
    } kind_t;

    // One job: the results caused by one input transfer.
    typedef struct packed {
        logic       has_bytes;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       has_end;
        logic       end_err;
    } job_t;

    // Maps a text character through the standard alphabet.
    function automatic logic [7:0] char_code(input logic [7:0] c);
        logic [7:0] code;
        if (c >= 8'h41 && c <= 8'h5A) begin
            code = c - 8'd65;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            code = c - 8'd71;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            code = c + 8'd4;
        end else if (c == 8'h2B) begin
            code = 8'd62;
        end else if (c == 8'h2F) begin
            code = 8'd63;
        end else if (c == 8'h3D) begin
            code = CODE_PAD;
        end else begin
            code = CODE_INVALID;
        end
        return code;
    endfunction

endpackage

>>> hdl/base64_decoder_top.sv
// Streaming base64 decoder: one character per cycle in, one result per cycle out,
// while the result channel does not stall. Results pass through the job queue and
// the back end's output register; a job of up to three bytes and an end result
// leaves one result per cycle as they are taken. The queue absorbs input bursts.
// Reset (aresetn low, synchronous) empties the queue and restarts the group position.
module base64_decoder_top #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_out_kind,
    output logic [7:0] m_out_byte,
    output logic       m_run_last
);

    logic           queue_full;
    logic           queue_empty;
    logic           job_push;
    logic           queue_pop;
    b64d_pkg::job_t job_in;
    b64d_pkg::job_t job_head;

    // Character classification and group collection.
    b64d_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_char     (s_in_char),
        .s_end_of_text (s_end_of_text),
        .queue_full    (queue_full),
        .job_push      (job_push),
        .job_data      (job_in)
    );

    // Job queue.
    b64d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_in),
        .full      (queue_full),
        .pop       (queue_pop),
        .head_data (job_head),
        .empty     (queue_empty)
    );

    // Result sequencing.
    b64d_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .head_data   (job_head),
        .queue_pop   (queue_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_kind  (m_out_kind),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last)
    );

endmodule

>>> hdl/b64d_front.sv
// Front end of the base64 decoder: maps characters and collects groups of four.
// Produces one job per transfer that causes results. Depends on b64d_pkg.
module b64d_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_in_char,
    input  logic             s_end_of_text,
    input  logic             queue_full,
    output logic             job_push,
    output b64d_pkg::job_t   job_data
);

    logic [1:0] group_position_reg;
    logic [1:0] group_position_next;
    logic [7:0] held_reg [3];
    logic [7:0] code;
    logic       accept;
    logic       group_done;
    logic       group_ok;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;
    assign code    = b64d_pkg::char_code(s_in_char);

    // A group is complete when the fourth code arrives.
    assign group_done = (group_position_reg == 2'd3);

    // The first two codes must be values; the last two may be values or padding.
    assign group_ok = !held_reg[0][7] && !held_reg[1][7]
                      && (held_reg[2] != b64d_pkg::CODE_INVALID)
                      && (code != b64d_pkg::CODE_INVALID);

    // Build the job for this character.
    always_comb begin
        job_data.has_bytes = group_done && group_ok;
        job_data.byte0     = {held_reg[0][5:0], held_reg[1][5:4]};
        job_data.byte1     = held_reg[2][7] ? 8'd0 : {held_reg[1][3:0], held_reg[2][5:2]};
        job_data.byte2     = code[7] ? 8'd0 : {held_reg[2][1:0], code[5:0]};
        job_data.has_end   = s_end_of_text;
        job_data.end_err   = !group_done;
    end

    assign job_push = accept && (job_data.has_bytes || job_data.has_end);

    // Group position advances per character and restarts at the end of the text.
    always_comb begin
        group_position_next = group_position_reg;
        if (accept) begin
            if (s_end_of_text) begin
                group_position_next = 2'd0;
            end else begin
                group_position_next = group_position_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_position_reg <= 2'd0;
        end else begin
            group_position_reg <= group_position_next;
        end
    end

    // Held codes are payload only; each is written before it is read.
    always_ff @(posedge aclk) begin
        if (accept && !group_done) begin
            held_reg[group_position_reg] <= code;
        end
    end

endmodule

>>> hdl/b64d_fifo.sv
// Short job queue between the front and back of the base64 decoder.
// Holds DEPTH job records in registers. Depends on b64d_pkg.
module b64d_fifo #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  b64d_pkg::job_t   push_data,
    output logic             full,
    input  logic             pop,
    output b64d_pkg::job_t   head_data,
    output logic             empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    b64d_pkg::job_t  store_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == CntW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = store_reg[rd_ptr_reg];

    // Pointers wrap at the queue depth; the count tracks occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Job storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/b64d_back.sv
// Base64 decoder back end: sends each job's results one per cycle unless stalled.
// Drives the result channel through an output register. Depends on b64d_pkg.
module b64d_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             queue_empty,
    input  b64d_pkg::job_t   head_data,
    output logic             queue_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_out_kind,
    output logic [7:0]       m_out_byte,
    output logic             m_run_last
);

    logic [1:0] idx_reg;
    logic [1:0] step;
    logic       load;
    logic       last;
    logic       m_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic       run_last_reg;
    logic [1:0] kind_next;
    logic [7:0] byte_next;

    assign load = !queue_empty && (!m_valid_reg || m_ready);

    // A job without bytes starts directly at its end result.
    assign step = (idx_reg == 2'd0 && !head_data.has_bytes) ? 2'd3 : idx_reg;

    // Select the result for the current step.
    always_comb begin
        kind_next = b64d_pkg::KIND_BYTE;
        byte_next = 8'd0;
        last      = 1'b0;
        case (step)
            2'd0: begin
                byte_next = head_data.byte0;
            end
            2'd1: begin
                byte_next = head_data.byte1;
            end
            2'd2: begin
                byte_next = head_data.byte2;
                last      = !head_data.has_end;
            end
            default: begin
                kind_next = head_data.end_err ? b64d_pkg::KIND_END_ERR
                                              : b64d_pkg::KIND_END_OK;
                last      = 1'b1;
            end
        endcase
    end

    assign queue_pop = load && last;

    // Step counter and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg     <= last ? 2'd0 : step + 2'd1;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg     <= kind_next;
            byte_reg     <= byte_next;
            run_last_reg <= last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_kind = kind_reg;
    assign m_out_byte = byte_reg;
    assign m_run_last = run_last_reg;

endmodule

>>> hdl/b64d_checker.sv
// Port-level checker for the base64 decoder, bound to the top level.
// Depends on b64d_pkg for the result kinds.
module b64d_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_in_char,
    input logic       s_end_of_text,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_out_kind,
    input logic [7:0] m_out_byte,
    input logic       m_run_last
);

    // No result is offered in the cycle after reset.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // End results carry a zero byte.
    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_kind != b64d_pkg::KIND_BYTE) |-> (m_out_byte == 8'd0))
        else $error("end result with non-zero byte");

    // An end result always closes the results of its character.
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_kind != b64d_pkg::KIND_BYTE) |-> m_run_last)
        else $error("end result not marked last");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_kind)
                                   && $stable(m_out_byte) && $stable(m_run_last)))
        else $error("stalled result changed");

    // A waiting character transfer holds until it is accepted.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_in_char)
                                   && $stable(s_end_of_text)))
        else $error("waiting character changed");

endmodule

bind base64_decoder_top b64d_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_in_char     (s_in_char),
    .s_end_of_text (s_end_of_text),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_kind    (m_out_kind),
    .m_out_byte    (m_out_byte),
    .m_run_last    (m_run_last)
);

>>> tb/tb_base64_decoder_top.sv
// Self-checking testbench for the streaming base64 decoder (base64_decoder_top).
// Random texts and some directed rows are checked against a decode predictor in this file.
// Depends on b64d_pkg for result kinds and special codes, and on the decoder RTL.
`timescale 1ns / 1ps

module tb_base64_decoder_top;

    // Text character with a meaning of its own: the padding sign.
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Least number of random characters to send after the directed table; texts go whole.
    localparam int RANDOM_CHARS = 475;

    // One expected result transfer.
    typedef struct {
        b64d_pkg::kind_t kind;
        logic [7:0]      data;
        logic            last;
    } decoded_t;

    // One row of directed stimulus; a negative result count means the predictor decides.
    typedef struct {
        logic [7:0]      chr;
        logic            eot;
        int              nres;
        b64d_pkg::kind_t kind;
    } stim_row_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_char     = 8'h00;
    logic       s_end_of_text = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [1:0] m_out_kind;
    logic [7:0] m_out_byte;
    logic       m_run_last;

    // Predictor state: position in the current group and the codes held so far.
    logic [1:0] grp_pos;
    logic [7:0] group_codes [3];

    decoded_t   fresh_results [$];
    decoded_t   awaited_results [$];
    stim_row_t  directed_rows [0:24];
    int         error_count   = 0;
    int         result_count  = 0;
    int         random_chars  = 0;
    logic [7:0] text_chars [$];

    base64_decoder_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_char     (s_in_char),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_kind    (m_out_kind),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last)
    );

    // Clock with a 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Idle length: mostly none or short, now and then long; none at all in a calm stretch.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Character to 6-bit value, or one of the two special codes.
    function automatic logic [7:0] char_to_code(input logic [7:0] c);
        if (c inside {[8'h41:8'h5A]}) begin
            return c - 8'h41;
        end else if (c inside {[8'h61:8'h7A]}) begin
            return c - 8'h61 + 8'd26;
        end else if (c inside {[8'h30:8'h39]}) begin
            return c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            return 8'd62;
        end else if (c == 8'h2F) begin
            return 8'd63;
        end else if (c == PAD_CHAR) begin
            return b64d_pkg::CODE_PAD;
        end
        return b64d_pkg::CODE_INVALID;
    endfunction

    // 6-bit value to its alphabet character, for building well-formed texts.
    function automatic logic [7:0] code_to_char(input int v);
        if (v < 26) begin
            return 8'(32'h41 + v);
        end else if (v < 52) begin
            return 8'(32'h61 + v - 26);
        end else if (v < 62) begin
            return 8'(32'h30 + v - 52);
        end else if (v == 62) begin
            return 8'h2B;
        end
        return 8'h2F;
    endfunction

    function automatic void add_result(input b64d_pkg::kind_t kind, input logic [7:0] data);
        decoded_t r;
        r.kind = kind;
        r.data = data;
        r.last = 1'b0;
        fresh_results.push_back(r);
    endfunction

    // Works out the results of one accepted character and advances the group state.
    function automatic void decode_char(input logic [7:0] chr, input logic eot);
        logic [7:0] code;
        decoded_t   tail;
        fresh_results.delete();
        code = char_to_code(chr);
        if (grp_pos < 2'd3) begin
            group_codes[grp_pos] = code;
            grp_pos = grp_pos + 2'd1;
        end else begin
            grp_pos = 2'd0;
            // A group survives unless code one or two is special or a later one is invalid.
            if (!(group_codes[0][7] || group_codes[1][7] ||
                  group_codes[2] == b64d_pkg::CODE_INVALID ||
                  code == b64d_pkg::CODE_INVALID)) begin
                add_result(b64d_pkg::KIND_BYTE, {group_codes[0][5:0], group_codes[1][5:4]});
                add_result(b64d_pkg::KIND_BYTE, group_codes[2][7] ? 8'h00 :
                                      {group_codes[1][3:0], group_codes[2][5:2]});
                // Padding in the third place still lends its low bits to the last byte.
                add_result(b64d_pkg::KIND_BYTE,
                           code[7] ? 8'h00 : {group_codes[2][1:0], code[5:0]});
            end
            group_codes = '{default: 8'h00};
        end
        if (eot) begin
            add_result(grp_pos == 2'd0 ? b64d_pkg::KIND_END_OK : b64d_pkg::KIND_END_ERR,
                       8'h00);
            grp_pos = 2'd0;
            group_codes = '{default: 8'h00};
        end
        if (fresh_results.size() > 0) begin
            tail = fresh_results.pop_back();
            tail.last = 1'b1;
            fresh_results.push_back(tail);
        end
    endfunction

    // Offers one character after an idle gap and records what it should cause.
    task automatic send_char(input logic [7:0] chr, input logic eot, input int nres,
                             input b64d_pkg::kind_t kind, input int gap);
        decoded_t typed;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_in_char     <= chr;
        s_end_of_text <= eot;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        decode_char(chr, eot);
        if (nres < 0) begin
            foreach (fresh_results[i]) begin
                awaited_results.push_back(fresh_results[i]);
            end
        end else if (nres == 1) begin
            typed.kind = kind;
            typed.data = 8'h00;
            typed.last = 1'b1;
            awaited_results.push_back(typed);
        end
    endtask

    // Builds one text: mostly whole groups of alphabet characters, some broken or noisy.
    task automatic build_text();
        int mode;
        int groups;
        int pads;
        int len;
        int r;
        text_chars.delete();
        mode = $urandom_range(0, 9);
        if (mode <= 6) begin
            groups = $urandom_range(1, 4);
            pads   = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
            for (int g = 0; g < groups; g++) begin
                for (int k = 0; k < 4; k++) begin
                    if (g == groups - 1 && k >= 4 - pads) begin
                        text_chars.push_back(PAD_CHAR);
                    end else begin
                        text_chars.push_back(code_to_char($urandom_range(0, 63)));
                    end
                end
            end
        end else begin
            len = $urandom_range(1, 13);
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(0, 9);
                if (mode == 9 || r < 2) begin
                    text_chars.push_back(8'($urandom_range(0, 255)));
                end else if (r < 3) begin
                    text_chars.push_back(PAD_CHAR);
                end else begin
                    text_chars.push_back(code_to_char($urandom_range(0, 63)));
                end
            end
        end
    endtask

    // Result side: random stalls, with calm stretches of no stalls at all.
    int stall_left = 0;
    int calm_left  = 0;
    bit rx_calm    = 1'b0;

    always @(posedge aclk) begin
        if (calm_left == 0) begin
            rx_calm   <= ($urandom_range(0, 3) == 0);
            calm_left <= $urandom_range(20, 100);
        end else begin
            calm_left <= calm_left - 1;
        end
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= pick_gap(1'b0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Each result transfer is compared with the oldest expectation.
    always @(posedge aclk) begin
        decoded_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count <= result_count + 1;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result %0d with none expected (kind %0d byte %02h)",
                                          result_count, m_out_kind, m_out_byte));
            end else begin
                want = awaited_results.pop_front();
                if (m_out_kind !== want.kind) begin
                    report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                              result_count, m_out_kind, want.kind));
                end
                if (m_out_byte !== want.data) begin
                    report_mismatch($sformatf("result %0d byte %02h, expected %02h",
                                              result_count, m_out_byte, want.data));
                end
                if (m_run_last !== want.last) begin
                    report_mismatch($sformatf("result %0d run_last %0b, expected %0b",
                                              result_count, m_run_last, want.last));
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random texts.
    initial begin
        bit tx_calm;
        grp_pos     = 2'd0;
        group_codes = '{default: 8'h00};
        directed_rows = '{
            '{8'h00, 1'b1,  1, b64d_pkg::KIND_END_ERR},   // zero byte alone: incomplete text
            '{8'h41, 1'b1,  1, b64d_pkg::KIND_END_ERR},   // one letter alone
            '{8'h2F, 1'b0,  0, b64d_pkg::KIND_BYTE},      // all ones: "////"
            '{8'h2F, 1'b0,  0, b64d_pkg::KIND_BYTE},
            '{8'h2F, 1'b0,  0, b64d_pkg::KIND_BYTE},
            '{8'h2F, 1'b1, -1, b64d_pkg::KIND_BYTE},
            '{8'h41, 1'b0,  0, b64d_pkg::KIND_BYTE},      // padding third, value fourth: "AB=A"
            '{8'h42, 1'b0,  0, b64d_pkg::KIND_BYTE},
            '{PAD_CHAR, 1'b0, 0, b64d_pkg::KIND_BYTE},
            '{8'h41, 1'b0, -1, b64d_pkg::KIND_BYTE},
            '{8'h41, 1'b0,  0, b64d_pkg::KIND_BYTE},      // padding second drops the group
            '{PAD_CHAR, 1'b0, 0, b64d_pkg::KIND_BYTE},
            '{8'h41, 1'b0,  0, b64d_pkg::KIND_BYTE},
            '{8'h41, 1'b0,  0, b64d_pkg::KIND_BYTE},
            '{8'h2B, 1'b0,  0, b64d_pkg::KIND_BYTE},      // both symbols, final pad: "+/z="
            '{8'h2F, 1'b0,  0, b64d_pkg::KIND_BYTE},
            '{8'h7A, 1'b0,  0, b64d_pkg::KIND_BYTE},
            '{PAD_CHAR, 1'b0, -1, b64d_pkg::KIND_BYTE},
            '{8'h30, 1'b0,  0, b64d_pkg::KIND_BYTE},      // invalid third code drops the group
            '{8'h61, 1'b0,  0, b64d_pkg::KIND_BYTE},
            '{8'h2A, 1'b0,  0, b64d_pkg::KIND_BYTE},
            '{8'h5A, 1'b1,  1, b64d_pkg::KIND_END_OK},
            '{8'h7A, 1'b0,  0, b64d_pkg::KIND_BYTE},      // three characters then the end
            '{8'h7A, 1'b0,  0, b64d_pkg::KIND_BYTE},
            '{8'hFF, 1'b1,  1, b64d_pkg::KIND_END_ERR}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_char(directed_rows[i].chr, directed_rows[i].eot, directed_rows[i].nres,
                      directed_rows[i].kind, pick_gap(1'b0));
        end

        while (random_chars < RANDOM_CHARS) begin
            build_text();
            tx_calm = ($urandom_range(0, 3) == 0);
            foreach (text_chars[k]) begin
                send_char(text_chars[k], k == text_chars.size() - 1, -1, b64d_pkg::KIND_BYTE,
                          pick_gap(tx_calm));
                random_chars++;
            end
        end
        s_valid <= 1'b0;

        // Drain, then allow time for any stray result to show.
        while (awaited_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (50) @(posedge aclk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/b64d_pkg.sv
hdl/b64d_front.sv
hdl/b64d_fifo.sv
hdl/b64d_back.sv
hdl/base64_decoder_top.sv
hdl/b64d_checker.sv
tb/tb_base64_decoder_top.sv
